// ===== rtl/wav_header_chunk_parser_macros.svh =====
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_macros.svh
// Assertion macros shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_CHUNK_PARSER_MACROS_SVH
`define WAV_HEADER_CHUNK_PARSER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define WAVHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define WAVHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wavhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wavhp_pkg
// Types and constants for the WAV header chunk parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam int WINDOW_BYTES_DEF = 1024;

  // chunk ids, first byte in low bits
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  // parse phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_RIFF      = 3'd1;
  localparam logic [2:0] PH_HDR_FMT   = 3'd2;
  localparam logic [2:0] PH_HDR_DATA  = 3'd3;
  localparam logic [2:0] PH_FMT_BODY  = 3'd4;
  localparam logic [2:0] PH_SKIP_FMT  = 3'd5;
  localparam logic [2:0] PH_SKIP_DATA = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  // result status codes
  localparam logic [1:0] ST_DATA_FOUND = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_EARLY_END  = 2'd2;
  localparam logic [1:0] ST_FMT_SHORT  = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] riff_size;
    logic [31:0] form_word;
    logic [31:0] fmt_size;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } result_t;

endpackage

// ===== rtl/wavhp_in_reg.sv =====
// ----------------------------------------------------------------------------
// wavhp_in_reg
// Input register: holds one byte request until the parser takes it.
// ----------------------------------------------------------------------------
module wavhp_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wavhp_pkg::item_t in_item,
  input  logic            advance,
  output logic            step,
  output wavhp_pkg::item_t item
);

  logic held;

  assign step     = held && advance;
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item <= '0;
    end else if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/wavhp_core.sv =====
// ----------------------------------------------------------------------------
// wavhp_core
// Per-byte parse state: RIFF header, chunk walk, fmt capture, result decision.
// ----------------------------------------------------------------------------
module wavhp_core #(
  parameter int WINDOW_BYTES = wavhp_pkg::WINDOW_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  wavhp_pkg::item_t   item,
  output logic               res_valid,
  output wavhp_pkg::result_t res
);

  localparam int POS_W = $clog2(WINDOW_BYTES) + 1;
  localparam int LIMIT = WINDOW_BYTES - 8;

  logic [2:0]       phase, phase_next;
  logic [POS_W-1:0] pos, pos_next, b_pos;
  logic [3:0]       hcnt, hcnt_next, b_hcnt;
  logic [31:0]      id_sh, id_next, b_id;
  logic [31:0]      size_sh, size_next, b_size;
  logic [POS_W-1:0] skip, skip_next, b_skip;
  logic [31:0]      f_riff, f_form, f_fsize, f_rate, f_brate;
  logic [15:0]      f_tag, f_chan, f_align, f_bits;
  logic [31:0]      f_riff_next, f_form_next, f_fsize_next, f_rate_next, f_brate_next;
  logic [15:0]      f_tag_next, f_chan_next, f_align_next, f_bits_next;

  logic [2:0]  eff_phase;
  logic [31:0] sz_in, id_in;
  logic [33:0] next_hdr;
  logic        want_data, beyond;
  logic        emit;
  logic [1:0]  emit_status;
  logic [31:0] emit_dsize;

  always_comb begin
    eff_phase = item.first_byte ? wavhp_pkg::PH_RIFF : phase;
    // a new file starts from cleared state
    b_pos  = item.first_byte ? '0 : pos;
    b_hcnt = item.first_byte ? '0 : hcnt;
    b_id   = item.first_byte ? '0 : id_sh;
    b_size = item.first_byte ? '0 : size_sh;
    b_skip = item.first_byte ? '0 : skip;

    sz_in     = {item.byte_value, b_size[31:8]};
    id_in     = {item.byte_value, b_id[31:8]};
    next_hdr  = {{(34-POS_W){1'b0}}, b_pos} + 34'd8 + {2'b00, sz_in};
    beyond    = next_hdr > 34'(LIMIT);
    want_data = (eff_phase == wavhp_pkg::PH_HDR_DATA);

    phase_next   = eff_phase;
    pos_next     = b_pos;
    hcnt_next    = b_hcnt;
    id_next      = b_id;
    size_next    = b_size;
    skip_next    = b_skip;
    f_riff_next  = item.first_byte ? '0 : f_riff;
    f_form_next  = item.first_byte ? '0 : f_form;
    f_fsize_next = item.first_byte ? '0 : f_fsize;
    f_tag_next   = item.first_byte ? '0 : f_tag;
    f_chan_next  = item.first_byte ? '0 : f_chan;
    f_rate_next  = item.first_byte ? '0 : f_rate;
    f_brate_next = item.first_byte ? '0 : f_brate;
    f_align_next = item.first_byte ? '0 : f_align;
    f_bits_next  = item.first_byte ? '0 : f_bits;
    emit         = 1'b0;
    emit_status  = wavhp_pkg::ST_DATA_FOUND;
    emit_dsize   = '0;

    unique case (eff_phase)
      wavhp_pkg::PH_RIFF: begin
        size_next = sz_in;
        if (b_hcnt == 4'd7) begin
          f_riff_next = sz_in;
        end
        if (b_hcnt == 4'd11) begin
          f_form_next = sz_in;
          pos_next    = POS_W'(12);
          hcnt_next   = '0;
          phase_next  = wavhp_pkg::PH_HDR_FMT;
        end else begin
          hcnt_next = b_hcnt + 4'd1;
        end
      end
      wavhp_pkg::PH_HDR_FMT, wavhp_pkg::PH_HDR_DATA: begin
        if (b_hcnt < 4'd4) begin
          id_next = id_in;
        end else begin
          size_next = sz_in;
        end
        hcnt_next = b_hcnt + 4'd1;
        if (b_hcnt == 4'd7) begin
          // id is complete, size completes with this byte
          if (b_id == (want_data ? wavhp_pkg::ID_DATA : wavhp_pkg::ID_FMT)) begin
            if (want_data) begin
              emit        = 1'b1;
              emit_status = wavhp_pkg::ST_DATA_FOUND;
              emit_dsize  = sz_in;
            end else begin
              f_fsize_next = sz_in;
              if (sz_in < 32'd16) begin
                emit        = 1'b1;
                emit_status = wavhp_pkg::ST_FMT_SHORT;
              end else if (beyond) begin
                emit        = 1'b1;
                emit_status = wavhp_pkg::ST_NOT_FOUND;
              end else begin
                pos_next   = next_hdr[POS_W-1:0];
                skip_next  = POS_W'(sz_in - 32'd16);
                hcnt_next  = '0;
                phase_next = wavhp_pkg::PH_FMT_BODY;
              end
            end
          end else if (b_pos >= POS_W'(LIMIT) || beyond) begin
            emit        = 1'b1;
            emit_status = wavhp_pkg::ST_NOT_FOUND;
          end else begin
            pos_next  = next_hdr[POS_W-1:0];
            skip_next = sz_in[POS_W-1:0];
            hcnt_next = '0;
            if (sz_in == 32'd0) begin
              phase_next = want_data ? wavhp_pkg::PH_HDR_DATA : wavhp_pkg::PH_HDR_FMT;
            end else begin
              phase_next = want_data ? wavhp_pkg::PH_SKIP_DATA : wavhp_pkg::PH_SKIP_FMT;
            end
          end
        end
      end
      wavhp_pkg::PH_FMT_BODY: begin
        size_next = sz_in;
        unique case (b_hcnt)
          4'd1:    f_tag_next   = sz_in[31:16];
          4'd3:    f_chan_next  = sz_in[31:16];
          4'd7:    f_rate_next  = sz_in;
          4'd11:   f_brate_next = sz_in;
          4'd13:   f_align_next = sz_in[31:16];
          4'd15:   f_bits_next  = sz_in[31:16];
          default: ;
        endcase
        if (b_hcnt == 4'd15) begin
          hcnt_next  = '0;
          phase_next = (b_skip == '0) ? wavhp_pkg::PH_HDR_DATA : wavhp_pkg::PH_SKIP_DATA;
        end else begin
          hcnt_next = b_hcnt + 4'd1;
        end
      end
      wavhp_pkg::PH_SKIP_FMT, wavhp_pkg::PH_SKIP_DATA: begin
        if (b_skip != '0) begin
          skip_next = b_skip - POS_W'(1);
        end
        if (b_skip <= POS_W'(1)) begin
          hcnt_next  = '0;
          phase_next = (eff_phase == wavhp_pkg::PH_SKIP_DATA) ?
                       wavhp_pkg::PH_HDR_DATA : wavhp_pkg::PH_HDR_FMT;
        end
      end
      wavhp_pkg::PH_IDLE, wavhp_pkg::PH_DONE: begin
        phase_next = eff_phase;
      end
    endcase

    // end of stream with no decision yet
    if (!emit && item.final_byte &&
        eff_phase != wavhp_pkg::PH_IDLE && eff_phase != wavhp_pkg::PH_DONE) begin
      emit        = 1'b1;
      emit_status = wavhp_pkg::ST_EARLY_END;
      emit_dsize  = '0;
    end
    if (emit) begin
      phase_next = wavhp_pkg::PH_DONE;
    end
  end

  assign res_valid           = step && emit;
  assign res.status          = emit_status;
  assign res.riff_size       = f_riff_next;
  assign res.form_word       = f_form_next;
  assign res.fmt_size        = f_fsize_next;
  assign res.format_tag      = f_tag_next;
  assign res.channel_count   = f_chan_next;
  assign res.sample_rate     = f_rate_next;
  assign res.byte_rate       = f_brate_next;
  assign res.block_align     = f_align_next;
  assign res.bits_per_sample = f_bits_next;
  assign res.data_size       = emit_dsize;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wavhp_pkg::PH_IDLE;
      hcnt  <= '0;
      pos   <= '0;
      skip  <= '0;
    end else if (step) begin
      phase <= phase_next;
      hcnt  <= hcnt_next;
      pos   <= pos_next;
      skip  <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      id_sh   <= id_next;
      size_sh <= size_next;
      f_riff  <= f_riff_next;
      f_form  <= f_form_next;
      f_fsize <= f_fsize_next;
      f_tag   <= f_tag_next;
      f_chan  <= f_chan_next;
      f_rate  <= f_rate_next;
      f_brate <= f_brate_next;
      f_align <= f_align_next;
      f_bits  <= f_bits_next;
    end
  end

endmodule

// ===== rtl/wavhp_out_reg.sv =====
// ----------------------------------------------------------------------------
// wavhp_out_reg
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module wavhp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  wavhp_pkg::result_t load_res,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               free,
  output wavhp_pkg::result_t res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

// ===== rtl/wav_header_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// wav_header_chunk_parser
// Byte-stream WAV header parser: RIFF header, chunk walk to fmt and data.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one file byte per request, with
// first_byte marking offset 0 of a file and final_byte its last byte.
// Output channel (out_valid/out_ready) carries at most one result per file:
// status plus the RIFF size, form word, fmt fields and data chunk size.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// The byte that decides a result is held in the input register, and the result
// is loaded from it into the result register, where the receiver can take it.
// The per-byte work is one shift, a 34-bit add and compare for the next chunk
// header offset, and a capture into the field registers.
// Reset puts the parser idle; bytes are ignored until one has first_byte.
// When the receiver stalls with a result pending, the held byte waits in the
// input register and in_ready drops once that register is occupied.
// ----------------------------------------------------------------------------
module wav_header_chunk_parser #(
  parameter int WINDOW_BYTES = wavhp_pkg::WINDOW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] riff_size,
  output logic [31:0] form_word,
  output logic [31:0] fmt_size,
  output logic [15:0] format_tag,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [31:0] byte_rate,
  output logic [15:0] block_align,
  output logic [15:0] bits_per_sample,
  output logic [31:0] data_size
);

  `include "wav_header_chunk_parser_macros.svh"

  wavhp_pkg::item_t   in_item, item;
  wavhp_pkg::result_t core_res, res;
  logic               step, free, res_valid;

  assign in_item.byte_value = byte_value;
  assign in_item.first_byte = first_byte;
  assign in_item.final_byte = final_byte;

  wavhp_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (free),
    .step     (step),
    .item     (item)
  );

  wavhp_core #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (core_res)
  );

  wavhp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (core_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .res       (res)
  );

  assign status          = res.status;
  assign riff_size       = res.riff_size;
  assign form_word       = res.form_word;
  assign fmt_size        = res.fmt_size;
  assign format_tag      = res.format_tag;
  assign channel_count   = res.channel_count;
  assign sample_rate     = res.sample_rate;
  assign byte_rate       = res.byte_rate;
  assign block_align     = res.block_align;
  assign bits_per_sample = res.bits_per_sample;
  assign data_size       = res.data_size;

  `WAVHP_ASSERT(a_result_from_step, ($rose(out_valid) |-> $past(step)), "result without byte")
  `WAVHP_ASSERT(a_ready_low, (!in_ready |-> (out_valid && !out_ready)), "ready low w/o stall")
  `WAVHP_ASSERT_NEXT(a_taken, out_valid && out_ready && !res_valid, !out_valid, "result repeated")

endmodule

// ===== bench/wav_header_chunk_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_test
// Self-checking bench for the WAV header chunk parser. A queue of file bytes
// feeds a valid/ready driver; a clocked monitor runs a local copy of the
// parse on every accepted byte and checks each result field by field.
// Directed files cover field extremes, short fmt, window edges, early end,
// restart and stray bytes; random files follow under four idling phases.
// ----------------------------------------------------------------------------
module wav_header_chunk_parser_test;

  localparam int          WINDOW      = wavhp_pkg::WINDOW_BYTES_DEF;
  localparam logic [33:0] HDR_LIMIT   = 34'(WINDOW - 8);
  localparam logic [31:0] ID_RIFF     = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE     = 32'h4556_4157;
  localparam logic [31:0] ID_LIST     = 32'h5453_494C;
  localparam int          DRAIN_CYCLES = 16;

  // captured field slots
  localparam int CAP_RIFF  = 0;
  localparam int CAP_FORM  = 1;
  localparam int CAP_FSIZE = 2;
  localparam int CAP_TAG   = 3;
  localparam int CAP_CHAN  = 4;
  localparam int CAP_RATE  = 5;
  localparam int CAP_BRATE = 6;
  localparam int CAP_ALIGN = 7;
  localparam int CAP_BITS  = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'h00;
  logic        first_byte = 1'b0;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] riff_size;
  logic [31:0] form_word;
  logic [31:0] fmt_size;
  logic [15:0] format_tag;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [31:0] data_size;

  wav_header_chunk_parser u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_value(byte_value), .first_byte(first_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .riff_size(riff_size), .form_word(form_word),
    .fmt_size(fmt_size), .format_tag(format_tag), .channel_count(channel_count),
    .sample_rate(sample_rate), .byte_rate(byte_rate), .block_align(block_align),
    .bits_per_sample(bits_per_sample), .data_size(data_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wavhp_pkg::item_t   byte_feed[$];
  wavhp_pkg::result_t wav_results_due[$];
  logic [7:0]         file_bytes[$];
  wavhp_pkg::item_t   feed_head;

  int bytes_issued = 0;
  int bytes_taken = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int files_sent = 0;
  int file_bytes_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  // local parse state
  logic [2:0]  parse_phase;
  logic [31:0] parse_pos;
  logic [4:0]  parse_cnt;
  logic [31:0] parse_id;
  logic [31:0] parse_word;
  logic [32:0] parse_skip;
  logic [31:0] parse_cap[9];

  function automatic void clear_parse();
    parse_pos  = '0;
    parse_cnt  = '0;
    parse_id   = '0;
    parse_word = '0;
    parse_skip = '0;
    for (int i = 0; i < 9; i++) parse_cap[i] = '0;
  endfunction

  function automatic void post_result(input logic [1:0] st, input logic [31:0] dsize);
    wavhp_pkg::result_t r;
    r.status          = st;
    r.riff_size       = parse_cap[CAP_RIFF];
    r.form_word       = parse_cap[CAP_FORM];
    r.fmt_size        = parse_cap[CAP_FSIZE];
    r.format_tag      = parse_cap[CAP_TAG][15:0];
    r.channel_count   = parse_cap[CAP_CHAN][15:0];
    r.sample_rate     = parse_cap[CAP_RATE];
    r.byte_rate       = parse_cap[CAP_BRATE];
    r.block_align     = parse_cap[CAP_ALIGN][15:0];
    r.bits_per_sample = parse_cap[CAP_BITS][15:0];
    r.data_size       = dsize;
    wav_results_due.push_back(r);
    status_tally[st]++;
    parse_phase = wavhp_pkg::PH_DONE;
  endfunction

  function automatic void leave_section(input bit after_fmt);
    parse_cnt = '0;
    if (parse_skip == 0)
      parse_phase = after_fmt ? wavhp_pkg::PH_HDR_DATA : wavhp_pkg::PH_HDR_FMT;
    else
      parse_phase = after_fmt ? wavhp_pkg::PH_SKIP_DATA : wavhp_pkg::PH_SKIP_FMT;
  endfunction

  // chunk header complete: returns 1 when it decides the result
  function automatic bit judge_chunk();
    logic [33:0] nxt;
    logic        want_data;
    logic [31:0] want_id;
    want_data = (parse_phase == wavhp_pkg::PH_HDR_DATA);
    want_id   = want_data ? wavhp_pkg::ID_DATA : wavhp_pkg::ID_FMT;
    nxt       = {2'b00, parse_pos} + 34'd8 + {2'b00, parse_word};
    if (parse_id == want_id) begin
      if (want_data) begin
        post_result(wavhp_pkg::ST_DATA_FOUND, parse_word);
        return 1'b1;
      end
      parse_cap[CAP_FSIZE] = parse_word;
      if (parse_word < 16) begin
        post_result(wavhp_pkg::ST_FMT_SHORT, '0);
        return 1'b1;
      end
      if (nxt > HDR_LIMIT) begin
        post_result(wavhp_pkg::ST_NOT_FOUND, '0);
        return 1'b1;
      end
      parse_pos   = nxt[31:0];
      parse_skip  = {1'b0, parse_word} - 33'd16;
      parse_cnt   = '0;
      parse_phase = wavhp_pkg::PH_FMT_BODY;
      return 1'b0;
    end
    if ({2'b00, parse_pos} >= HDR_LIMIT || nxt > HDR_LIMIT) begin
      post_result(wavhp_pkg::ST_NOT_FOUND, '0);
      return 1'b1;
    end
    parse_pos  = nxt[31:0];
    parse_skip = {1'b0, parse_word};
    leave_section(want_data);
    return 1'b0;
  endfunction

  function automatic bit consume_byte(input logic [7:0] b);
    case (parse_phase)
      wavhp_pkg::PH_RIFF: begin
        parse_word = {b, parse_word[31:8]};
        if (parse_cnt == 7) parse_cap[CAP_RIFF] = parse_word;
        if (parse_cnt == 11) begin
          parse_cap[CAP_FORM] = parse_word;
          parse_pos   = 32'd12;
          parse_cnt   = '0;
          parse_phase = wavhp_pkg::PH_HDR_FMT;
        end else begin
          parse_cnt++;
        end
      end
      wavhp_pkg::PH_HDR_FMT, wavhp_pkg::PH_HDR_DATA: begin
        if (parse_cnt < 4) parse_id = {b, parse_id[31:8]};
        else parse_word = {b, parse_word[31:8]};
        if (parse_cnt == 7) return judge_chunk();
        parse_cnt++;
      end
      wavhp_pkg::PH_FMT_BODY: begin
        parse_word = {b, parse_word[31:8]};
        case (parse_cnt)
          5'd1:  parse_cap[CAP_TAG]   = {16'h0, parse_word[31:16]};
          5'd3:  parse_cap[CAP_CHAN]  = {16'h0, parse_word[31:16]};
          5'd7:  parse_cap[CAP_RATE]  = parse_word;
          5'd11: parse_cap[CAP_BRATE] = parse_word;
          5'd13: parse_cap[CAP_ALIGN] = {16'h0, parse_word[31:16]};
          5'd15: parse_cap[CAP_BITS]  = {16'h0, parse_word[31:16]};
          default: ;
        endcase
        if (parse_cnt >= 15) leave_section(1'b1);
        else parse_cnt++;
      end
      wavhp_pkg::PH_SKIP_FMT, wavhp_pkg::PH_SKIP_DATA: begin
        if (parse_skip > 0) parse_skip--;
        if (parse_skip == 0) begin
          parse_cnt   = '0;
          parse_phase = (parse_phase == wavhp_pkg::PH_SKIP_DATA) ?
                        wavhp_pkg::PH_HDR_DATA : wavhp_pkg::PH_HDR_FMT;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fb, input logic lb);
    bit decided;
    if (fb) begin
      clear_parse();
      parse_phase = wavhp_pkg::PH_RIFF;
    end
    if (parse_phase != wavhp_pkg::PH_IDLE && parse_phase != wavhp_pkg::PH_DONE) begin
      decided = consume_byte(b);
      if (!decided && lb) post_result(wavhp_pkg::ST_EARLY_END, '0);
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
      mismatches++;
    end
  endtask

  // request driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || bytes_taken == bytes_issued) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          feed_head = byte_feed.pop_front();
          in_valid     <= 1'b1;
          byte_value   <= feed_head.byte_value;
          first_byte   <= feed_head.first_byte;
          final_byte   <= feed_head.final_byte;
          bytes_issued <= bytes_issued + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: results checked before the byte of this edge is predicted
  always @(posedge clk) begin
    wavhp_pkg::result_t got;
    wavhp_pkg::result_t want;
    if (rst) begin
      parse_phase = wavhp_pkg::PH_IDLE;
      clear_parse();
    end else begin
      if (out_valid && out_ready) begin
        got = {status, riff_size, form_word, fmt_size, format_tag, channel_count,
               sample_rate, byte_rate, block_align, bits_per_sample, data_size};
        if (wav_results_due.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with none expected, status %0d",
                     results_seen, got.status);
          mismatches++;
        end else begin
          want = wav_results_due.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("riff_size", want.riff_size, got.riff_size);
          check_field("form_word", want.form_word, got.form_word);
          check_field("fmt_size", want.fmt_size, got.fmt_size);
          check_field("format_tag", 32'(want.format_tag), 32'(got.format_tag));
          check_field("channel_count", 32'(want.channel_count),
                      32'(got.channel_count));
          check_field("sample_rate", want.sample_rate, got.sample_rate);
          check_field("byte_rate", want.byte_rate, got.byte_rate);
          check_field("block_align", 32'(want.block_align), 32'(got.block_align));
          check_field("bits_per_sample", 32'(want.bits_per_sample),
                      32'(got.bits_per_sample));
          check_field("data_size", want.data_size, got.data_size);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        parse_byte(byte_value, first_byte, final_byte);
        bytes_taken = bytes_taken + 1;
      end
    end
  end

  // ---- file builders -------------------------------------------------------
  function automatic void add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void add_half(input logic [15:0] h);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endfunction

  function automatic void add_rand(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_fill(input int n, input logic [7:0] v);
    for (int i = 0; i < n; i++) file_bytes.push_back(v);
  endfunction

  function automatic void add_riff(input logic [31:0] size, input logic [31:0] form);
    add_word(ID_RIFF);
    add_word(size);
    add_word(form);
  endfunction

  function automatic void add_fmt(input logic [31:0] size, input logic [15:0] tag,
                                  input logic [15:0] chan, input logic [31:0] rate,
                                  input logic [31:0] brate, input logic [15:0] align,
                                  input logic [15:0] bits);
    add_word(wavhp_pkg::ID_FMT);
    add_word(size);
    add_half(tag);
    add_half(chan);
    add_word(rate);
    add_word(brate);
    add_half(align);
    add_half(bits);
  endfunction

  task automatic send_file(input int keep, input bit with_final);
    wavhp_pkg::item_t it;
    for (int i = 0; i < keep; i++) begin
      it.byte_value = file_bytes[i];
      it.first_byte = (i == 0);
      it.final_byte = with_final && (i == keep - 1);
      byte_feed.push_back(it);
    end
    files_sent++;
    file_bytes_sent += keep;
    file_bytes.delete();
  endtask

  // stray bytes with no first_byte
  task automatic add_noise(input int n);
    wavhp_pkg::item_t it;
    repeat (n) begin
      it.byte_value = 8'($urandom_range(255));
      it.first_byte = 1'b0;
      it.final_byte = 1'($urandom_range(1));
      byte_feed.push_back(it);
    end
  endtask

  // RIFF size, form word and every fmt body byte filled with one value
  function automatic void build_flat(input logic [7:0] v, input logic [31:0] dsize);
    add_riff({4{v}}, {4{v}});
    add_word(wavhp_pkg::ID_FMT);
    add_word(32'd16);
    add_fill(16, v);
    add_word(wavhp_pkg::ID_DATA);
    add_word(dsize);
  endfunction

  // fmt at 12, optional skip chunk, then a tail header near the window end
  function automatic void build_edge(input int fmt_len, input int skip_len,
                                     input logic [31:0] tail_id);
    add_riff($urandom, ID_WAVE);
    add_word(wavhp_pkg::ID_FMT);
    add_word(fmt_len);
    add_rand(fmt_len);
    if (skip_len >= 0) begin
      add_word(ID_LIST);
      add_word(skip_len);
      add_rand(skip_len);
    end
    add_word(tail_id);
    add_word(32'h0000_0020);
    add_rand(2);
  endfunction

  function automatic logic [31:0] pick_id(input bit pre_fmt);
    int r;
    r = $urandom_range(9);
    if (r < 3) return pre_fmt ? wavhp_pkg::ID_DATA : wavhp_pkg::ID_FMT;
    if (r == 3) return ID_LIST;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_skip();
    int r;
    r = $urandom_range(19);
    if (r == 0) return $urandom;
    if (r == 1) return 32'd0;
    return $urandom_range(12);
  endfunction

  function automatic logic [31:0] pick_fmt_size();
    int r;
    r = $urandom_range(19);
    if (r == 0) return $urandom;
    if (r < 3) return $urandom_range(15);
    return 16 + $urandom_range(8);
  endfunction

  function automatic void add_chunk(input logic [31:0] id, input logic [31:0] size);
    add_word(id);
    add_word(size);
    if (size <= 64) add_rand(size);
  endfunction

  task automatic gen_random_file();
    logic [31:0] fsize;
    int          r;
    int          len;
    add_word(($urandom_range(9) == 0) ? $urandom : ID_RIFF);
    add_word($urandom);
    add_word(($urandom_range(7) == 0) ? $urandom : ID_WAVE);
    repeat ($urandom_range(3) / 2 + $urandom_range(1)) add_chunk(pick_id(1'b1), pick_skip());
    fsize = pick_fmt_size();
    add_word(wavhp_pkg::ID_FMT);
    add_word(fsize);
    add_rand(16);
    if (fsize > 16 && fsize <= 64) add_rand(fsize - 16);
    repeat ($urandom_range(3) / 2 + $urandom_range(1)) add_chunk(pick_id(1'b0), pick_skip());
    add_word(wavhp_pkg::ID_DATA);
    add_word($urandom);
    add_rand($urandom_range(4));
    len = file_bytes.size();
    r = $urandom_range(9);
    if (r < 2) send_file($urandom_range(len, 1), 1'b1);
    else if (r == 2) send_file(len, 1'b0);
    else send_file(len, 1'b1);
  endtask

  task automatic run_random(input int n_bytes, input int n_files);
    int b0;
    int f0;
    b0 = file_bytes_sent;
    f0 = files_sent;
    while (file_bytes_sent - b0 < n_bytes || files_sent - f0 < n_files) begin
      gen_random_file();
      if ($urandom_range(4) == 0) add_noise($urandom_range(4, 1));
    end
  endtask

  task automatic wait_drained();
    while (byte_feed.size() != 0 || bytes_taken != bytes_issued ||
           wav_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_directed();
    // stray bytes before any file is opened
    add_noise(3);
    build_flat(8'hFF, 32'hFFFF_FFFF);
    send_file(file_bytes.size(), 1'b1);
    build_flat(8'h00, 32'h0);
    add_rand(3);
    send_file(file_bytes.size(), 1'b1);
    // data ahead of fmt, long fmt, second fmt after the first
    add_riff(32'd100, ID_WAVE);
    add_chunk(wavhp_pkg::ID_DATA, 32'd4);
    add_chunk(ID_LIST, 32'd0);
    add_fmt(32'd18, 16'd1, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
    add_rand(2);
    add_chunk(wavhp_pkg::ID_FMT, 32'd6);
    add_word(wavhp_pkg::ID_DATA);
    add_word(32'h0000_1000);
    add_rand(4);
    send_file(file_bytes.size(), 1'b1);
    // fmt too short
    add_riff($urandom, ID_WAVE);
    add_word(wavhp_pkg::ID_FMT);
    add_word(32'd15);
    add_rand(15);
    send_file(file_bytes.size(), 1'b1);
    add_riff($urandom, ID_WAVE);
    add_chunk(wavhp_pkg::ID_FMT, 32'd0);
    send_file(file_bytes.size(), 1'b1);
    // sizes that push the next header past the window
    add_riff($urandom, ID_WAVE);
    add_fmt(32'hFFFF_FFFF, 16'hFFFF, 16'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    send_file(file_bytes.size(), 1'b1);
    add_riff($urandom, ID_WAVE);
    add_word(ID_LIST);
    add_word(32'h8000_0000);
    send_file(file_bytes.size(), 1'b1);
    // early ends: lone byte, inside RIFF header, inside fmt body, inside a skip
    file_bytes.push_back(8'h52);
    send_file(1, 1'b1);
    build_flat(8'h3C, 32'd8);
    send_file(6, 1'b1);
    build_flat(8'hC3, 32'd8);
    send_file(30, 1'b1);
    add_riff($urandom, ID_WAVE);
    add_chunk(ID_LIST, 32'd10);
    send_file(24, 1'b1);
    // restart in the middle of a file
    build_flat(8'h5A, 32'h1234_5678);
    send_file(25, 1'b0);
    build_flat(8'hA5, 32'h8765_4321);
    send_file(file_bytes.size(), 1'b1);
    // next header offset landing exactly on the window limit, then one past;
    // files are cut short once the window decision is made
    build_edge(996, -1, wavhp_pkg::ID_DATA);
    send_file(24, 1'b1);
    build_edge(997, -1, wavhp_pkg::ID_DATA);
    send_file(20, 1'b1);
    add_riff($urandom, ID_WAVE);
    add_chunk(ID_LIST, 32'd996);
    add_rand(4);
    send_file(24, 1'b1);
    add_riff($urandom, ID_WAVE);
    add_chunk(ID_LIST, 32'd997);
    send_file(file_bytes.size(), 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    run_directed();
    run_random(200, 3);
    wait_drained();

    sender_idle_pct = 81;
    recv_stall_pct  = 0;
    run_random(200, 3);
    wait_drained();

    sender_idle_pct = 0;
    recv_stall_pct  = 81;
    run_random(200, 3);
    wait_drained();

    sender_idle_pct = 32;
    recv_stall_pct  = 32;
    run_random(200, 3);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d files, %0d file bytes, %0d results under four idling mixes",
             files_sent, file_bytes_sent, results_seen);
    $display("statuses: %0d data found, %0d not found, %0d early end, %0d short fmt",
             status_tally[wavhp_pkg::ST_DATA_FOUND], status_tally[wavhp_pkg::ST_NOT_FOUND],
             status_tally[wavhp_pkg::ST_EARLY_END], status_tally[wavhp_pkg::ST_FMT_SHORT]);
    if (wav_results_due.size() != 0)
      $display("%0d expected results never arrived", wav_results_due.size());
    if (mismatches == 0 && wav_results_due.size() == 0) begin
      $display("wav_header_chunk_parser_test: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("wav_header_chunk_parser_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", wav_results_due.size());
    $display("wav_header_chunk_parser_test: FAIL");
    $finish;
  end

endmodule
